FILE: src/breakpoint_linear_interpolator_top_macros.svh
// Assertion helpers shared by the interpolator RTL.
`ifndef BREAKPOINT_LINEAR_INTERPOLATOR_TOP_MACROS_SVH
`define BREAKPOINT_LINEAR_INTERPOLATOR_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while in reset.
`define BLI_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while in reset.
`define BLI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/bli_pkg.sv
package bli_pkg;

  localparam int unsigned MaxPoints = 256;

  typedef enum logic [1:0] {
    CMD_CLEAR      = 2'd0,
    CMD_APPEND     = 2'd1,
    CMD_QUERY      = 2'd2,
    CMD_QUERY_HINT = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    cmd_e               command;
    logic        [31:0] point_or_query_time;
    logic signed [31:0] point_value;
  } in_t;

  typedef struct packed {
    logic signed [31:0] interpolated_value;
    status_e            status;
  } out_t;

  // One breakpoint held by a cell.
  typedef struct packed {
    logic        [31:0] tm;
    logic signed [31:0] val;
  } pt_t;

  // Segment endpoints handed to the interpolation unit.
  typedef struct packed {
    logic        [31:0] t0;
    logic signed [31:0] v0;
    logic        [31:0] t1;
    logic signed [31:0] v1;
  } seg_t;

endpackage

FILE: src/bli_cell.sv
// One breakpoint slot of the ring; loads a new point or takes its neighbor's.
module bli_cell (
  input  logic           clk_i,
  input  logic           wr_en_i,
  input  bli_pkg::pt_t   wr_pt_i,
  input  logic           shift_en_i,
  input  bli_pkg::pt_t   nbr_pt_i,
  output bli_pkg::pt_t   pt_o
);

  bli_pkg::pt_t pt_q;

  // Load on append, otherwise advance the ring
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      pt_q <= wr_pt_i;
    end else if (shift_en_i) begin
      pt_q <= nbr_pt_i;
    end
  end

  assign pt_o = pt_q;

endmodule

FILE: src/bli_lerp.sv
// Serial interpolation: shift-add multiply of |v1-v0| by (t-t0), then
// restoring division by (t1-t0), one bit per cycle each.
module bli_lerp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  bli_pkg::seg_t      seg_i,
  input  logic        [31:0] t_i,
  output logic               done_o,
  output logic signed [31:0] value_o
);

  typedef enum logic [3:0] {
    L_IDLE = 4'b0001,
    L_MUL  = 4'b0010,
    L_DIV  = 4'b0100,
    L_FIN  = 4'b1000
  } lstate_e;

  lstate_e            state_q;
  logic        [5:0]  cnt_q;
  logic        [31:0] span_q;
  logic        [31:0] into_q;
  logic        [32:0] mag_q;
  logic               neg_q;
  logic signed [31:0] v0_q;
  logic        [64:0] acc_q;
  logic        [31:0] rem_q;

  logic signed [32:0] diff;
  logic        [32:0] trial;
  logic               qbit;
  logic signed [33:0] sum;

  assign diff  = 33'(seg_i.v1) - 33'(seg_i.v0);
  assign trial = {rem_q, acc_q[32]};
  assign qbit  = (trial >= {1'b0, span_q});
  assign sum   = neg_q ? (34'(v0_q) - 34'(signed'({1'b0, acc_q[32:0]})))
                       : (34'(v0_q) + 34'(signed'({1'b0, acc_q[32:0]})));

  // Control sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
      cnt_q   <= '0;
    end else begin
      unique case (state_q)
        L_IDLE: begin
          if (start_i) begin
            cnt_q   <= '0;
            state_q <= (seg_i.t1 == seg_i.t0) ? L_FIN : L_MUL;
          end
        end
        L_MUL: begin
          if (cnt_q == 6'd31) begin
            cnt_q   <= '0;
            state_q <= L_DIV;
          end else begin
            cnt_q <= cnt_q + 6'd1;
          end
        end
        L_DIV: begin
          // Load the remainder first, then one step per dividend bit below the top 32
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd33) begin
            state_q <= L_FIN;
          end
        end
        L_FIN: state_q <= L_IDLE;
        default: state_q <= L_IDLE;
      endcase
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      L_IDLE: begin
        if (start_i) begin
          span_q <= seg_i.t1 - seg_i.t0;
          into_q <= t_i - seg_i.t0;
          neg_q  <= diff[32];
          mag_q  <= diff[32] ? 33'(-diff) : 33'(diff);
          v0_q   <= seg_i.v0;
          acc_q  <= '0;
        end
      end
      L_MUL: begin
        // Take one multiplier bit, MSB first
        acc_q  <= {acc_q[63:0], 1'b0} + (into_q[31] ? 65'(mag_q) : 65'd0);
        into_q <= {into_q[30:0], 1'b0};
      end
      L_DIV: begin
        // Quotient is below 2^33, so the top 32 bits start below the divisor
        if (cnt_q == 6'd0) begin
          rem_q <= acc_q[64:33];
          acc_q <= {32'd0, acc_q[32:0]};
        end else begin
          rem_q <= qbit ? 32'(trial - {1'b0, span_q}) : trial[31:0];
          acc_q <= {32'd0, acc_q[31:0], qbit};
        end
      end
      L_FIN: ;
      default: ;
    endcase
  end

  assign done_o  = (state_q == L_FIN);
  assign value_o = sum[31:0];

endmodule

FILE: src/breakpoint_linear_interpolator_top.sv
// Breakpoint table with piecewise-linear lookup. Points live in a ring of
// MAX_POINTS cells that rotates one position per cycle during a scan; a
// query rotates the ring once all the way round, watching adjacent pairs at
// the head cell, then picks the segment and, on a hit, runs the serial
// multiply/divide unit (one bit per cycle). Clear, append and a query on an
// empty table skip the scan. One item is in flight at a time; a finished
// result sits in the output register so the next item can be taken.
`include "breakpoint_linear_interpolator_top_macros.svh"

module breakpoint_linear_interpolator_top #(
  parameter int unsigned MAX_POINTS = bli_pkg::MaxPoints
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  bli_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output bli_pkg::out_t out_data_o
);

  localparam int unsigned IdxW = $clog2(MAX_POINTS);
  localparam int unsigned CntW = $clog2(MAX_POINTS + 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_PICK = 5'b00100,
    S_LERP = 5'b01000,
    S_EMIT = 5'b10000
  } state_e;

  state_e              state_q;
  bli_pkg::cmd_e       cmd_q;
  logic [31:0]         t_q;
  logic [CntW-1:0]     count_q;
  logic [IdxW-1:0]     hint_q;
  logic [IdxW-1:0]     k_q;
  bli_pkg::pt_t        prev_q;
  logic                hit0_q;
  logic                hith_q;
  logic                hint_ok_q;
  logic [IdxW-1:0]     seg0_q;
  logic [IdxW-1:0]     segh_q;
  bli_pkg::seg_t       end0_q;
  bli_pkg::seg_t       endh_q;
  bli_pkg::out_t       res_q;
  logic                out_valid_q;
  bli_pkg::out_t       out_q;

  bli_pkg::pt_t        cell_pt [MAX_POINTS];
  bli_pkg::pt_t        head;
  bli_pkg::pt_t        wr_pt;
  logic                in_fire;
  logic                full;
  logic                append_ok;
  logic                in_tbl;
  logic                bracket;
  logic [IdxW-1:0]     seg_idx;
  logic                use_hint;
  logic                sel_hit;
  logic [IdxW-1:0]     sel_seg;
  bli_pkg::seg_t       sel_end;
  logic                lerp_start;
  logic                lerp_done;
  logic signed [31:0]  lerp_value;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign full       = (count_q == CntW'(MAX_POINTS));
  assign append_ok  = in_fire && (in_data_i.command == bli_pkg::CMD_APPEND) && !full;
  assign wr_pt      = '{tm: in_data_i.point_or_query_time, val: in_data_i.point_value};

  // Ring of breakpoint cells; cell 0 is the head seen by the scan
  for (genvar p = 0; p < MAX_POINTS; p++) begin : g_cell
    bli_cell u_cell (
      .clk_i      (clk_i),
      .wr_en_i    (append_ok && (count_q == CntW'(p))),
      .wr_pt_i    (wr_pt),
      .shift_en_i (state_q == S_SCAN),
      .nbr_pt_i   (cell_pt[(p + 1) % MAX_POINTS]),
      .pt_o       (cell_pt[p])
    );
  end

  // Pair check at the head: segment k-1 spans prev .. head
  assign head     = cell_pt[0];
  assign seg_idx  = k_q - IdxW'(1);
  assign in_tbl   = (CntW'(k_q) < count_q);
  assign bracket  = (k_q != '0) && in_tbl && (prev_q.tm <= t_q) && (head.tm >= t_q);

  // Choose between the from-start and from-hint scan results
  assign use_hint = (cmd_q == bli_pkg::CMD_QUERY_HINT) && hint_ok_q;
  assign sel_hit  = use_hint ? hith_q : hit0_q;
  assign sel_seg  = use_hint ? segh_q : seg0_q;
  assign sel_end  = use_hint ? endh_q : end0_q;
  assign lerp_start = (state_q == S_PICK) && sel_hit;

  bli_lerp u_lerp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (lerp_start),
    .seg_i   (sel_end),
    .t_i     (t_q),
    .done_o  (lerp_done),
    .value_o (lerp_value)
  );

  // Command sequencing and table bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cmd_q       <= bli_pkg::CMD_CLEAR;
      count_q     <= '0;
      hint_q      <= '0;
      k_q         <= '0;
      hit0_q      <= 1'b0;
      hith_q      <= 1'b0;
      hint_ok_q   <= 1'b0;
      seg0_q      <= '0;
      segh_q      <= '0;
      res_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // Drop the held result once the transfer completes
      if (out_valid_q && out_ready_i && (state_q != S_EMIT)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            cmd_q     <= in_data_i.command;
            k_q       <= '0;
            hit0_q    <= 1'b0;
            hith_q    <= 1'b0;
            hint_ok_q <= 1'b0;
            unique case (in_data_i.command)
              bli_pkg::CMD_CLEAR: begin
                count_q <= '0;
                hint_q  <= '0;
                res_q   <= '{interpolated_value: '0, status: bli_pkg::ST_OK};
                state_q <= S_EMIT;
              end
              bli_pkg::CMD_APPEND: begin
                if (full) begin
                  res_q <= '{interpolated_value: '0, status: bli_pkg::ST_FULL};
                end else begin
                  count_q <= count_q + CntW'(1);
                  res_q   <= '{interpolated_value: '0, status: bli_pkg::ST_OK};
                end
                state_q <= S_EMIT;
              end
              bli_pkg::CMD_QUERY, bli_pkg::CMD_QUERY_HINT: begin
                if (count_q == '0) begin
                  res_q   <= '{interpolated_value: '0, status: bli_pkg::ST_RANGE};
                  state_q <= S_EMIT;
                end else begin
                  state_q <= S_SCAN;
                end
              end
              default: ;
            endcase
          end
        end
        S_SCAN: begin
          if (k_q == hint_q) begin
            hint_ok_q <= in_tbl && (t_q > head.tm);
          end
          if (bracket && !hit0_q) begin
            hit0_q <= 1'b1;
            seg0_q <= seg_idx;
          end
          if (bracket && (seg_idx >= hint_q) && !hith_q) begin
            hith_q <= 1'b1;
            segh_q <= seg_idx;
          end
          k_q <= k_q + IdxW'(1);
          if (k_q == IdxW'(MAX_POINTS - 1)) begin
            state_q <= S_PICK;
          end
        end
        S_PICK: begin
          if (sel_hit) begin
            if (cmd_q == bli_pkg::CMD_QUERY_HINT) begin
              hint_q <= sel_seg;
            end
            state_q <= S_LERP;
          end else begin
            if (cmd_q == bli_pkg::CMD_QUERY_HINT && !use_hint) begin
              hint_q <= '0;
            end
            res_q   <= '{interpolated_value: '0, status: bli_pkg::ST_RANGE};
            state_q <= S_EMIT;
          end
        end
        S_LERP: begin
          if (lerp_done) begin
            res_q   <= '{interpolated_value: lerp_value, status: bli_pkg::ST_OK};
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Scan payload: previous head point, segment endpoints, query time, result
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      t_q <= in_data_i.point_or_query_time;
    end
    if (state_q == S_SCAN) begin
      prev_q <= head;
      if (bracket && !hit0_q) begin
        end0_q <= '{t0: prev_q.tm, v0: prev_q.val, t1: head.tm, v1: head.val};
      end
      if (bracket && (seg_idx >= hint_q) && !hith_q) begin
        endh_q <= '{t0: prev_q.tm, v0: prev_q.val, t1: head.tm, v1: head.val};
      end
    end
    if (state_q == S_EMIT && (!out_valid_q || out_ready_i)) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `BLI_ASSERT_NEXT(a_leave_idle, in_fire, state_q != S_IDLE, "accepted item left block idle")
  `BLI_ASSERT_IMPL(a_count_max, 1'b1, count_q <= CntW'(MAX_POINTS), "point count above table size")
  `BLI_ASSERT_IMPL(a_lerp_owned, lerp_done, state_q == S_LERP, "interpolation done outside lerp state")
  `BLI_ASSERT_IMPL(a_hit_order, hith_q && hit0_q, seg0_q <= segh_q, "hinted hit before first hit")

endmodule

FILE: tb/breakpoint_linear_interpolator_top_tb.sv
module breakpoint_linear_interpolator_top_tb;

  localparam int unsigned Depth = bli_pkg::MaxPoints;

  logic          clk_i;
  logic          rst_ni;
  logic          in_valid_i;
  logic          in_ready_o;
  bli_pkg::in_t  in_data_i;
  logic          out_valid_o;
  logic          out_ready_i;
  bli_pkg::out_t out_data_o;

  breakpoint_linear_interpolator_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // Shadow copy of the breakpoint table
  logic [31:0]        bp_time [Depth];
  logic signed [31:0] bp_val  [Depth];
  int unsigned        bp_count;
  int unsigned        hint_seg;

  bli_pkg::out_t pending_results[$];
  int            error_count;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #40000000;
    $display("*** FAILED ***");
    $finish;
  end

  // Interpolate within segment seg at time t, truncating the step toward v0
  function automatic logic signed [31:0] lerp_at(int unsigned seg, logic [31:0] t);
    logic [63:0] span;
    logic [63:0] into;
    logic signed [63:0] v0;
    logic signed [63:0] diff;
    logic [63:0] mag;
    logic [63:0] step;
    span = 64'(bp_time[seg+1] - bp_time[seg]);
    into = 64'(t - bp_time[seg]);
    v0   = 64'(bp_val[seg]);
    diff = 64'(bp_val[seg+1]) - v0;
    if (span == 0) return bp_val[seg];
    mag  = (diff < 0) ? 64'(-diff) : 64'(diff);
    step = (mag * into) / span;
    return (diff < 0) ? 32'(v0 - $signed(step)) : 32'(v0 + $signed(step));
  endfunction

  // Advance the shadow table by one command and return its result
  function automatic bli_pkg::out_t table_response(bli_pkg::in_t item);
    bli_pkg::out_t r;
    int unsigned start;
    int unsigned i;
    bit hit;
    logic [31:0] t;
    r.interpolated_value = '0;
    r.status = bli_pkg::ST_OK;
    t = item.point_or_query_time;
    hit = 1'b0;
    case (item.command)
      bli_pkg::CMD_CLEAR: begin
        bp_count = 0;
        hint_seg = 0;
      end
      bli_pkg::CMD_APPEND: begin
        if (bp_count >= Depth) r.status = bli_pkg::ST_FULL;
        else begin
          bp_time[bp_count] = t;
          bp_val[bp_count]  = item.point_value;
          bp_count++;
        end
      end
      default: begin
        if (bp_count == 0) r.status = bli_pkg::ST_RANGE;
        else begin
          start = 0;
          if (item.command == bli_pkg::CMD_QUERY_HINT) begin
            if (hint_seg >= bp_count) hint_seg = 0;
            if (!(t > bp_time[hint_seg])) hint_seg = 0;
            start = hint_seg;
          end
          for (i = start; i + 1 < bp_count && !hit; i++) begin
            if (bp_time[i] <= t && bp_time[i+1] >= t) begin
              hit = 1'b1;
              r.interpolated_value = lerp_at(i, t);
              if (item.command == bli_pkg::CMD_QUERY_HINT) hint_seg = i;
            end
          end
          if (!hit) r.status = bli_pkg::ST_RANGE;
        end
      end
    endcase
    return r;
  endfunction

  // Drive one transfer, record what it should produce, then sometimes idle a while
  task automatic send_item(bli_pkg::cmd_e c, logic [31:0] t, logic signed [31:0] v);
    int gap;
    in_valid_i <= 1'b1;
    in_data_i  <= '{command: c, point_or_query_time: t, point_value: v};
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_results.push_back(table_response('{c, t, v}));
    gap = $urandom_range(0, 5);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Random receiver stalls and result checking
  initial begin
    bli_pkg::out_t want;
    int stall;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result %h", $realtime, out_data_o);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_data_o.interpolated_value !== want.interpolated_value) begin
          $display("%0t value expected %h actual %h", $realtime,
                   want.interpolated_value, out_data_o.interpolated_value);
          error_count++;
        end
        if (out_data_o.status !== want.status) begin
          $display("%0t status expected %0d actual %0d", $realtime,
                   want.status, out_data_o.status);
          error_count++;
        end
      end
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
    end
  end

  task automatic test_edges();
    send_item(bli_pkg::CMD_QUERY, 32'd5, 0);
    send_item(bli_pkg::CMD_QUERY_HINT, 32'd5, 0);
    send_item(bli_pkg::CMD_APPEND, 32'h0001_0000, 32'sh7fff_ffff);
    send_item(bli_pkg::CMD_QUERY, 32'h0001_0000, 0);
    send_item(bli_pkg::CMD_APPEND, 32'hffff_ffff, 32'sh8000_0000);
    send_item(bli_pkg::CMD_QUERY, 32'h8000_0000, 32'sh1234_5678);
    send_item(bli_pkg::CMD_QUERY_HINT, 32'hffff_ffff, 0);
    send_item(bli_pkg::CMD_QUERY_HINT, 32'h0001_0000, 0);
    send_item(bli_pkg::CMD_QUERY, 32'h0, 0);
    send_item(bli_pkg::CMD_APPEND, 32'hffff_ffff, 32'sd100);
    send_item(bli_pkg::CMD_QUERY, 32'hffff_ffff, 0);
    send_item(bli_pkg::CMD_APPEND, 32'h0000_0010, 32'sh0000_0001);
    send_item(bli_pkg::CMD_APPEND, 32'h0000_0020, 32'sh0000_0005);
    send_item(bli_pkg::CMD_QUERY, 32'h0000_0018, 0);
    send_item(bli_pkg::CMD_QUERY_HINT, 32'hffff_fff0, 0);
    send_item(bli_pkg::CMD_QUERY_HINT, 32'hffff_fff8, 0);
    send_item(bli_pkg::CMD_CLEAR, 32'hffff_ffff, 32'sh7fff_ffff);
    send_item(bli_pkg::CMD_QUERY, 32'd0, 0);
  endtask

  // Fill the table past its depth
  task automatic test_full_table();
    int k;
    send_item(bli_pkg::CMD_CLEAR, 0, 0);
    for (k = 0; k < Depth + 3; k++)
      send_item(bli_pkg::CMD_APPEND, 32'(k) << 12, 32'($urandom()));
    send_item(bli_pkg::CMD_QUERY, 32'(Depth - 1) << 12, 0);
    send_item(bli_pkg::CMD_QUERY_HINT, 32'(Depth / 2) << 12, 0);
  endtask

  // Small, mostly ascending tables with a mix of in-range and fully random queries
  task automatic test_random(int items);
    int sent;
    int n;
    int k;
    logic [31:0] t;
    logic [31:0] tmax;
    sent = 0;
    while (sent < items) begin
      send_item(bli_pkg::CMD_CLEAR, $urandom(), $urandom());
      n = $urandom_range(0, 10);
      t = $urandom_range(0, 1000);
      for (k = 0; k < n; k++) begin
        if ($urandom_range(0, 9) == 0) t = $urandom();
        else if ($urandom_range(0, 5) != 0) t = t + $urandom_range(0, 32'h0fff_ffff);
        send_item(bli_pkg::CMD_APPEND, t, $urandom());
      end
      tmax = t;
      for (k = 0; k < 12; k++) begin
        if ($urandom_range(0, 2) == 0) t = $urandom();
        else if (n > 0)
          t = bp_time[0] + 32'(64'($urandom()) % (64'(tmax - bp_time[0]) + 64'd1));
        send_item($urandom_range(0, 1) ? bli_pkg::CMD_QUERY_HINT : bli_pkg::CMD_QUERY,
                  t, $urandom());
      end
      sent += n + 13;
      if ($urandom_range(0, 20) == 0) wait_drained();
    end
  endtask

  initial begin
    error_count = 0;
    bp_count    = 0;
    hint_seg    = 0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_edges();
    wait_drained();
    test_full_table();
    test_random(1550);
    wait_drained();
    repeat (400) @(posedge clk_i);
    if (error_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
